>>> hdl/pbrm_pkg.sv
// pbrm_pkg: shared constants, codes and types of the pulse beat rate meter
// used by the controller, the datapath, the divider and the top level
// no dependencies
package pbrm_pkg;

	// port and ring geometry
	localparam int PORTS      = 4;
	localparam int PORT_W     = 2;
	localparam int HIST_DEPTH = 16;
	localparam int CUR_W      = $clog2(HIST_DEPTH);
	localparam int DONE_W     = $clog2(HIST_DEPTH + 1);
	localparam int MEM_DEPTH  = PORTS * HIST_DEPTH;
	localparam int MEM_AW     = $clog2(MEM_DEPTH);

	// data widths
	localparam int TIME_W   = 32;
	localparam int BEAT_W   = 8;
	localparam int SUM_W    = BEAT_W + CUR_W;
	localparam int IVL_W    = 31;
	localparam int MINP_W   = 5;
	localparam int PPM_W    = 16;
	localparam int BPM_W    = 16;
	localparam int PROD_W   = SUM_W + PPM_W;
	localparam int DIV_STEPS = (PROD_W + 1) / 2;
	localparam int QUO_W    = 2 * DIV_STEPS;
	localparam int CNT_W    = $clog2(DIV_STEPS + 1);

	// stream and config port widths
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 31;

	// sensor byte codes
	localparam logic [BEAT_W-1:0] BYTE_PULSE = 8'h00;
	localparam logic [BEAT_W-1:0] BYTE_REST  = 8'h03;
	localparam logic [BEAT_W-1:0] BEAT_MAX   = 8'hFF;

	// config reset values
	localparam logic [IVL_W-1:0]  IVL_RESET  = 31'd23437500;
	localparam logic [MINP_W-1:0] MINP_RESET = 5'd8;
	localparam logic [PPM_W-1:0]  PPM_RESET  = 16'd120;
	localparam logic [BPM_W-1:0]  BPM_MAX    = 16'hFFFF;

	// config register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INTERVAL = 2'd0,
		CFG_MIN_PER  = 2'd1,
		CFG_PPM      = 2'd2,
		CFG_NONE     = 2'd3
	} cfg_idx_t;

	// item kinds
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_START  = 2'd2,
		OP_STOP   = 2'd3
	} op_t;

	// port modes
	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_RESTING = 2'd1,
		MODE_PULSING = 2'd2
	} mode_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic rd;
		logic update;
		logic div_start;
		logic emit;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_busy;
		logic out_free;
	} stat_t;

endpackage

>>> hdl/pbrm_div.sv
// pbrm_div: unsigned divider, restoring, two quotient bits per cycle
// depends on pbrm_pkg
module pbrm_div import pbrm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [DONE_W-1:0] divisor,
	output logic              busy,
	output logic [QUO_W-1:0]  quotient
);

	logic [QUO_W-1:0]  num_q;
	logic [DONE_W-1:0] rem_q;
	logic [DONE_W-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [DONE_W:0]   r_a, r_b;
	logic [DONE_W-1:0] rem_a, rem_b;
	logic              q_a, q_b;

	// two dependent restoring steps
	always_comb begin
		r_a   = {rem_q, num_q[QUO_W-1]};
		q_a   = (r_a >= {1'b0, den_q});
		rem_a = q_a ? DONE_W'(r_a - {1'b0, den_q}) : DONE_W'(r_a);
		r_b   = {rem_a, num_q[QUO_W-2]};
		q_b   = (r_b >= {1'b0, den_q});
		rem_b = q_b ? DONE_W'(r_b - {1'b0, den_q}) : DONE_W'(r_b);
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= QUO_W'(dividend);
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[QUO_W-3:0], q_a, q_b};
			rem_q <= rem_b;
		end
	end

	assign busy     = busy_q;
	assign quotient = num_q;

endmodule

>>> hdl/pbrm_dp.sv
// pbrm_dp: datapath with config registers, per-port state, beat ring memory,
// rate multiplier, divider and output register; depends on pbrm_pkg, pbrm_div
module pbrm_dp import pbrm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                stat,
	input  logic [1:0]           s_tuser,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	// captured item
	op_t               op_q;
	logic [PORT_W-1:0] port_q;
	logic [BEAT_W-1:0] byte_q;

	// config and time
	logic [IVL_W-1:0]  ivl_q;
	logic [MINP_W-1:0] minp_q;
	logic [PPM_W-1:0]  ppm_q;
	logic [TIME_W-1:0] time_q;

	// per-port state
	mode_t             mode_q   [PORTS];
	logic [TIME_W-1:0] begin_q  [PORTS];
	logic [BEAT_W-1:0] beats_q  [PORTS];
	logic [CUR_W-1:0]  cursor_q [PORTS];
	logic [DONE_W-1:0] done_q   [PORTS];
	logic [SUM_W-1:0]  sum_q    [PORTS];

	// beat ring memory, entries past the fill count are read but never used
	logic [BEAT_W-1:0] hist_mem [MEM_DEPTH];
	logic [BEAT_W-1:0] rd_q;

	// rate result
	logic              zero_q;
	mode_t             mode_res_q;

	// output register
	logic              out_valid_q;
	logic [PORT_W-1:0] out_port_q;
	mode_t             out_mode_q;
	logic [BPM_W-1:0]  out_bpm_q;

	// selected port view
	logic              port_ok;
	mode_t             mode_sel;
	logic [TIME_W-1:0] begin_sel;
	logic [BEAT_W-1:0] beats_sel;
	logic [CUR_W-1:0]  cur_sel;
	logic [DONE_W-1:0] done_sel;
	logic [SUM_W-1:0]  sum_sel;

	logic [MEM_AW-1:0] mem_addr;
	logic [TIME_W-1:0] elapsed;
	logic              roll;
	logic [BEAT_W-1:0] old_beats;
	logic [SUM_W:0]    sum_wide;
	logic [SUM_W-1:0]  sum_roll;
	logic [CUR_W-1:0]  cur_next;
	logic [DONE_W-1:0] done_next;
	mode_t             next_mode;
	logic [BEAT_W-1:0] beats_base;
	logic [BEAT_W-1:0] beats_new;
	logic              mem_we;
	logic [DONE_W-1:0] need;
	logic [PROD_W-1:0] product;
	logic              div_busy;
	logic [QUO_W-1:0]  quotient;
	logic [BPM_W-1:0]  bpm;

	// port view and sample update terms
	always_comb begin
		port_ok   = (32'(port_q) < PORTS);
		mode_sel  = mode_q[port_q];
		begin_sel = begin_q[port_q];
		beats_sel = beats_q[port_q];
		cur_sel   = cursor_q[port_q];
		done_sel  = done_q[port_q];
		sum_sel   = sum_q[port_q];
		mem_addr  = MEM_AW'(32'(port_q) * HIST_DEPTH + 32'(cur_sel));

		elapsed   = time_q - begin_sel;
		roll      = (elapsed > {1'b0, ivl_q});
		old_beats = (32'(done_sel) < HIST_DEPTH) ? '0 : rd_q;
		sum_wide  = {1'b0, sum_sel} - (SUM_W+1)'(old_beats) + (SUM_W+1)'(beats_sel);
		sum_roll  = sum_wide[SUM_W-1:0];
		cur_next  = (32'(cur_sel) == HIST_DEPTH - 1) ? '0 : cur_sel + CUR_W'(1);
		done_next = (32'(done_sel) < HIST_DEPTH) ? done_sel + DONE_W'(1) : done_sel;

		priority if (byte_q == BYTE_PULSE) next_mode = MODE_PULSING;
		else if (byte_q == BYTE_REST)      next_mode = MODE_RESTING;
		else                               next_mode = MODE_STOPPED;

		beats_base = roll ? '0 : beats_sel;
		beats_new  = (mode_sel == MODE_PULSING && next_mode == MODE_RESTING &&
			beats_base != BEAT_MAX) ? beats_base + BEAT_W'(1) : beats_base;

		mem_we = cmd.update && op_q == OP_SAMPLE && port_ok &&
			mode_sel != MODE_STOPPED && roll;
	end

	// threshold clamped to one..ring depth
	always_comb begin
		priority if (minp_q == '0)            need = DONE_W'(1);
		else if (32'(minp_q) > HIST_DEPTH)    need = DONE_W'(HIST_DEPTH);
		else                                  need = DONE_W'(minp_q);
	end

	assign product = PROD_W'(sum_sel) * PROD_W'(ppm_q);

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(s_tuser);
			port_q <= s_tdata[PORT_W-1:0];
			byte_q <= s_tdata[PORT_W +: BEAT_W];
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ivl_q  <= IVL_RESET;
			minp_q <= MINP_RESET;
			ppm_q  <= PPM_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_INTERVAL: ivl_q  <= cfg_data;
				CFG_MIN_PER:  minp_q <= cfg_data[MINP_W-1:0];
				CFG_PPM:      ppm_q  <= cfg_data[PPM_W-1:0];
				default: ;
			endcase
		end
	end

	// time counter and per-port state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			for (int i = 0; i < PORTS; i++) begin
				mode_q[i]   <= MODE_STOPPED;
				begin_q[i]  <= '0;
				beats_q[i]  <= '0;
				cursor_q[i] <= '0;
				done_q[i]   <= '0;
				sum_q[i]    <= '0;
			end
		end else if (cmd.update) begin
			unique case (op_q)
				OP_TICK: time_q <= time_q + TIME_W'(1);
				OP_SAMPLE: begin
					if (port_ok && mode_sel != MODE_STOPPED) begin
						if (roll) begin
							sum_q[port_q]    <= sum_roll;
							cursor_q[port_q] <= cur_next;
							done_q[port_q]   <= done_next;
							begin_q[port_q]  <= time_q;
						end
						beats_q[port_q] <= beats_new;
						mode_q[port_q]  <= next_mode;
					end
				end
				OP_START: begin
					if (port_ok && mode_sel == MODE_STOPPED) begin
						mode_q[port_q]   <= MODE_RESTING;
						begin_q[port_q]  <= time_q;
						beats_q[port_q]  <= '0;
						cursor_q[port_q] <= '0;
						done_q[port_q]   <= '0;
						sum_q[port_q]    <= '0;
					end
				end
				OP_STOP: begin
					if (port_ok) begin
						mode_q[port_q]   <= MODE_STOPPED;
						begin_q[port_q]  <= '0;
						beats_q[port_q]  <= '0;
						cursor_q[port_q] <= '0;
						done_q[port_q]   <= '0;
						sum_q[port_q]    <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// ring memory, one read and one write port
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= hist_mem[mem_addr];
		end
		if (mem_we) begin
			hist_mem[mem_addr] <= beats_sel;
		end
	end

	// rate qualifiers taken with the product
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			zero_q     <= !port_ok || (done_sel < need);
			mode_res_q <= port_ok ? mode_sel : MODE_STOPPED;
		end
	end

	pbrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (product),
		.divisor  (done_sel),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// force zero below the threshold, else saturate the quotient
	always_comb begin
		if (zero_q) begin
			bpm = '0;
		end else if (quotient > QUO_W'(BPM_MAX)) begin
			bpm = BPM_MAX;
		end else begin
			bpm = quotient[BPM_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_port_q <= port_q;
			out_mode_q <= mode_res_q;
			out_bpm_q  <= bpm;
		end
	end

	assign stat.div_busy = div_busy;
	assign stat.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_bpm_q,
		out_mode_q == MODE_PULSING, out_mode_q != MODE_STOPPED,
		out_mode_q, out_port_q};

endmodule

>>> hdl/pbrm_ctrl.sv
// pbrm_ctrl: sequencing state machine of the rate meter
// depends on pbrm_pkg
module pbrm_ctrl import pbrm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_READ = 6'b000010,
		ST_UPD  = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (!stat.div_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

>>> hdl/pulse_beat_rate_meter_top.sv
// pulse_beat_rate_meter_top: heart-rate meter for several sensor ports
// depends on pbrm_pkg, pbrm_ctrl, pbrm_dp (which holds pbrm_div)
//
//  channel  signals                              direction  payload
//  s_       tvalid tready tuser tdata            in         item kind, port and sensor byte
//  m_       tvalid tready tdata                  out        port, mode, flags, beats per minute
//  cfg_     valid ready index data               in         register write
//
// an item passes through memory read, state update, multiply, the two-bit-per-cycle divider,
// a state that sees the divider done and one that loads the output register, which waits
// while an untaken result is held there; the next item is accepted only after that load
// the output register lets the next item in while a result waits on m_tready
// reset is asynchronous, active low, and needs no clearing pass; ring entries
// are only used once the per-port period count shows they were written
module pulse_beat_rate_meter_top import pbrm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [1:0]           s_tuser,  // [1:0] op
	input  logic [S_TDATA_W-1:0] s_tdata,  // [1:0] port, [9:2] sensor_byte, rest zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [1:0] port_out, [3:2] mode, [4] active,
	                                       // [5] pulsing, [21:6] beats_per_minute
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	pbrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pbrm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

>>> tb/sv/pulse_beat_rate_meter_top_test.sv
// pulse_beat_rate_meter_top_test: self-checking bench for the pulse beat rate meter
// streams ticks, starts, stops and sensor bytes and checks every reading against its own predictor
// depends on pbrm_pkg and pulse_beat_rate_meter_top
`timescale 1ns / 1ps

module pulse_beat_rate_meter_top_test;
	import pbrm_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_WAIT  = 40;
	localparam int PRINT_CAP    = 40;

	typedef struct packed {
		op_t               op;
		logic [PORT_W-1:0] port;
		logic [BEAT_W-1:0] sensor_byte;
	} sensor_item_t;

	typedef struct packed {
		logic [PORT_W-1:0] port;
		logic [1:0]        mode;
		logic              active;
		logic              pulsing;
		logic [BPM_W-1:0]  bpm;
	} meter_reading_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [1:0]           s_tuser = '0;  // [1:0] op
	logic [S_TDATA_W-1:0] s_tdata = '0;  // [1:0] port, [9:2] sensor_byte, rest zero
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;       // [1:0] port_out, [3:2] mode, [4] active,
	                                     // [5] pulsing, [21:6] beats_per_minute
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_INTERVAL;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	// stimulus and expectation stores
	sensor_item_t   item_queue[$];
	meter_reading_t readings_due[$];

	// predictor state
	logic [TIME_W-1:0] tick_count;
	mode_t             slot_mode   [PORTS];
	logic [TIME_W-1:0] slot_begin  [PORTS];
	logic [BEAT_W-1:0] slot_beats  [PORTS];
	logic [CUR_W-1:0]  slot_cursor [PORTS];
	logic [DONE_W-1:0] slot_done   [PORTS];
	logic [SUM_W-1:0]  slot_sum    [PORTS];
	logic [BEAT_W-1:0] slot_ring   [PORTS][HIST_DEPTH];
	logic [IVL_W-1:0]  cfg_interval;
	logic [MINP_W-1:0] cfg_min_per;
	logic [PPM_W-1:0]  cfg_ppm;

	// run control and bookkeeping
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_requests = 0;
	int   hold_served = 0;
	int   hold_left = 0;
	int   quiet_cycles = 0;
	int   mismatches = 0;
	int   items_taken = 0;
	int   readings_checked = 0;
	int   nonzero_rates = 0;
	int   settings_written = 0;
	logic s_taken = 1'b0;
	wire  any_fire = (s_tvalid & s_tready) | (m_tvalid & m_tready) | (cfg_valid & cfg_ready);

	pulse_beat_rate_meter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// wipe one port's counters and ring
	function automatic void clear_slot(int p);
		slot_mode[p]   = MODE_STOPPED;
		slot_begin[p]  = '0;
		slot_beats[p]  = '0;
		slot_cursor[p] = '0;
		slot_done[p]   = '0;
		slot_sum[p]    = '0;
		for (int i = 0; i < HIST_DEPTH; i++) slot_ring[p][i] = '0;
	endfunction

	// advance the predictor by one item and return the reading it should produce
	function automatic meter_reading_t meter_step(sensor_item_t it);
		meter_reading_t    r;
		int                p;
		int                need;
		int                cnt;
		logic [TIME_W-1:0] elapsed;
		logic [CUR_W-1:0]  cur;
		mode_t             next_mode;
		logic [63:0]       prod;
		p = int'(it.port);
		if (it.op == OP_TICK) tick_count = tick_count + 1'b1;
		case (it.op)
			OP_SAMPLE: begin
				if (slot_mode[p] != MODE_STOPPED) begin
					// close the period once it has run past the interval
					elapsed = tick_count - slot_begin[p];
					if (elapsed > {1'b0, cfg_interval}) begin
						cur = slot_cursor[p];
						slot_sum[p] = slot_sum[p] - slot_ring[p][cur] + slot_beats[p];
						slot_ring[p][cur] = slot_beats[p];
						slot_cursor[p] = cur + 1'b1;
						slot_beats[p] = '0;
						if (32'(slot_done[p]) < HIST_DEPTH) slot_done[p] = slot_done[p] + 1'b1;
						slot_begin[p] = tick_count;
					end
					next_mode = MODE_STOPPED;
					if (it.sensor_byte == BYTE_PULSE) next_mode = MODE_PULSING;
					if (it.sensor_byte == BYTE_REST) next_mode = MODE_RESTING;
					// pulse to rest counts one beat, saturating
					if (slot_mode[p] == MODE_PULSING && next_mode == MODE_RESTING &&
					    slot_beats[p] != BEAT_MAX) begin
						slot_beats[p] = slot_beats[p] + 1'b1;
					end
					slot_mode[p] = next_mode;
				end
			end
			OP_START: begin
				if (slot_mode[p] == MODE_STOPPED) begin
					clear_slot(p);
					slot_mode[p] = MODE_RESTING;
					slot_begin[p] = tick_count;
				end
			end
			OP_STOP: clear_slot(p);
			default: ;
		endcase
		r.port    = it.port;
		r.mode    = slot_mode[p];
		r.active  = slot_mode[p] != MODE_STOPPED;
		r.pulsing = slot_mode[p] == MODE_PULSING;
		// rate from the ring, threshold clamped to one..ring depth
		need = int'(cfg_min_per);
		if (need < 1) need = 1;
		if (need > HIST_DEPTH) need = HIST_DEPTH;
		cnt = int'(slot_done[p]);
		if (cnt < need) begin
			r.bpm = '0;
		end else begin
			prod = (64'(slot_sum[p]) * 64'(cfg_ppm)) / 64'(cnt);
			r.bpm = (prod > 64'(BPM_MAX)) ? BPM_MAX : prod[BPM_W-1:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		if (mismatches < PRINT_CAP) begin
			$display("mismatch in %s at reading %0d: got %0d, want %0d",
			         what, readings_checked, got, want);
		end
		mismatches++;
	endtask

	// input driver: holds each transaction until it is accepted
	always @(negedge clk) begin : item_driver
		sensor_item_t it;
		if (!s_tvalid || s_taken) begin
			if (item_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				it = item_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= it.op;
				s_tdata  <= S_TDATA_W'({it.sensor_byte, it.port});
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output ready: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: register writes, accepted items and readings
	always @(posedge clk) begin : meter_monitor
		sensor_item_t   taken;
		meter_reading_t got;
		meter_reading_t want;
		s_taken <= s_tvalid && s_tready;
		if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_INTERVAL: cfg_interval = cfg_data[IVL_W-1:0];
				CFG_MIN_PER:  cfg_min_per = cfg_data[MINP_W-1:0];
				CFG_PPM:      cfg_ppm = cfg_data[PPM_W-1:0];
				default: ;
			endcase
			settings_written++;
		end
		// check readings before adding this edge's expectation
		if (m_tvalid && m_tready) begin
			got.port    = m_tdata[1:0];
			got.mode    = m_tdata[3:2];
			got.active  = m_tdata[4];
			got.pulsing = m_tdata[5];
			got.bpm     = m_tdata[21:6];
			if (readings_due.size() == 0) begin
				report_mismatch("reading with nothing expected", m_tdata, 0);
			end else begin
				want = readings_due.pop_front();
				if (got.port !== want.port) report_mismatch("port_out", got.port, want.port);
				if (got.mode !== want.mode) report_mismatch("mode", got.mode, want.mode);
				if (got.active !== want.active) report_mismatch("active", got.active, want.active);
				if (got.pulsing !== want.pulsing) begin
					report_mismatch("pulsing", got.pulsing, want.pulsing);
				end
				if (got.bpm !== want.bpm) report_mismatch("beats_per_minute", got.bpm, want.bpm);
				if (want.bpm != '0) nonzero_rates++;
			end
			readings_checked++;
		end
		if (s_tvalid && s_tready) begin
			taken.op          = op_t'(s_tuser);
			taken.port        = s_tdata[1:0];
			taken.sensor_byte = s_tdata[9:2];
			readings_due.push_back(meter_step(taken));
			items_taken++;
		end
	end

	// watchdog: too long without any transaction
	always @(posedge clk) begin
		if (any_fire || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles < STALL_LIMIT) begin
			quiet_cycles <= quiet_cycles + 1;
		end else begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_item(op_t op, int port, logic [BEAT_W-1:0] sensor_byte);
		sensor_item_t it;
		it.op = op;
		it.port = PORT_W'(port);
		it.sensor_byte = sensor_byte;
		item_queue.push_back(it);
	endtask

	// mostly running ports fed rest/pulse bytes, with some noise
	task automatic queue_random(int count);
		sensor_item_t it;
		int           pick;
		int           kind;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			kind = $urandom_range(99);
			it.port = PORT_W'($urandom_range(PORTS - 1));
			it.sensor_byte = BEAT_W'($urandom_range(255));
			if (pick < 33) begin
				it.op = OP_TICK;
			end else if (pick < 93) begin
				it.op = OP_SAMPLE;
				if (kind < 48) it.sensor_byte = BYTE_PULSE;
				else if (kind < 97) it.sensor_byte = BYTE_REST;
			end else if (pick < 99) begin
				it.op = OP_START;
			end else begin
				it.op = OP_STOP;
			end
			item_queue.push_back(it);
		end
	endtask

	task automatic write_register(cfg_idx_t idx, logic [CFG_DAT_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every item is in and every reading is out
	task automatic drain_meter();
		while (item_queue.size() != 0 || s_tvalid || readings_due.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	initial begin : run_sequence
		// predictor starts from the reset values
		tick_count   = '0;
		cfg_interval = IVL_RESET;
		cfg_min_per  = MINP_RESET;
		cfg_ppm      = PPM_RESET;
		for (int p = 0; p < PORTS; p++) clear_slot(p);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part with reset settings
		send_idle_pct = 22;
		recv_idle_pct = 70;
		push_item(OP_TICK,   0, 8'h00);
		push_item(OP_START,  0, 8'hFF);
		push_item(OP_SAMPLE, 0, BYTE_PULSE);
		push_item(OP_SAMPLE, 0, BYTE_REST);
		push_item(OP_SAMPLE, 0, 8'hFF);     // stopping byte keeps counters
		push_item(OP_SAMPLE, 0, BYTE_PULSE); // ignored on a stopped port
		push_item(OP_START,  1, 8'h00);
		push_item(OP_START,  1, 8'h00);     // already running, ignored
		push_item(OP_SAMPLE, 1, BYTE_PULSE);
		push_item(OP_STOP,   1, 8'h00);
		push_item(OP_START,  2, 8'h00);
		push_item(OP_START,  3, 8'h00);
		push_item(OP_SAMPLE, 3, 8'hAA);
		push_item(OP_SAMPLE, 3, 8'h55);
		push_item(OP_TICK,   3, 8'hFF);
		push_item(OP_STOP,   0, 8'h00);
		push_item(OP_TICK,   1, 8'h00);
		push_item(OP_TICK,   2, 8'h00);
		push_item(OP_SAMPLE, 2, BYTE_REST);
		push_item(OP_SAMPLE, 2, BYTE_PULSE);
		push_item(OP_SAMPLE, 2, 8'h01);
		push_item(OP_START,  0, 8'h00);
		drain_meter();

		// short periods, largest multiplier: rate saturation
		write_register(CFG_INTERVAL, 31'd4);
		write_register(CFG_MIN_PER, 31'd1);
		write_register(CFG_PPM, 31'd65535);
		push_item(OP_START, 1, 8'h00);
		push_item(OP_START, 2, 8'h00);
		push_item(OP_START, 3, 8'h00);
		queue_random(200);
		drain_meter();

		// interval of one, full ring needed, multiplier of one
		send_idle_pct = 70;
		recv_idle_pct = 22;
		write_register(CFG_INTERVAL, 31'd1);
		write_register(CFG_MIN_PER, 31'd16);
		write_register(CFG_PPM, 31'd1);
		queue_random(200);
		drain_meter();

		// one long period on port 0 so its beat count saturates
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_register(CFG_INTERVAL, 31'd2);
		write_register(CFG_MIN_PER, 31'd1);
		write_register(CFG_PPM, 31'd1);
		push_item(OP_STOP, 0, 8'h00);
		push_item(OP_START, 0, 8'h00);
		for (int k = 0; k < 260; k++) begin
			push_item(OP_SAMPLE, 0, BYTE_PULSE);
			push_item(OP_SAMPLE, 0, BYTE_REST);
		end
		repeat (3) push_item(OP_TICK, 0, 8'h00);
		push_item(OP_SAMPLE, 0, BYTE_REST);
		push_item(OP_SAMPLE, 0, BYTE_PULSE);
		drain_meter();

		// zero interval and zero threshold, which clamps up to one
		write_register(CFG_INTERVAL, 31'd0);
		write_register(CFG_MIN_PER, 31'd0);
		write_register(CFG_PPM, 31'd7);
		queue_random(150);
		drain_meter();

		// largest interval, threshold above the ring depth; receiver holds off
		write_register(CFG_INTERVAL, 31'h7FFF_FFFF);
		write_register(CFG_MIN_PER, 31'd31);
		write_register(CFG_PPM, 31'd300);
		hold_requests++;
		queue_random(200);
		drain_meter();

		$display("run covered %0d items, %0d readings (%0d with a nonzero rate), %0d register writes",
		         items_taken, readings_checked, nonzero_rates, settings_written);
		$display("mismatches found: %0d", mismatches);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
